@@ hdl/key_note_recorder_defines.svh @@
// Assertion macros used by the recorder RTL.
`ifndef KEY_NOTE_RECORDER_DEFINES_SVH
`define KEY_NOTE_RECORDER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside of reset.
`define KNR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define KNR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define KNR_ASSERT(label, prop, msg)
`define KNR_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ hdl/knr_pkg.sv @@
package knr_pkg;

   localparam int KEY_W      = 7;
   localparam int KEYS_W     = 3 * KEY_W;
   localparam int TONE_W     = 11;
   localparam int DUR_W      = 16;
   localparam int TICK_W     = 8;
   localparam int CNT_OUT_W  = 7;
   localparam int CMD_W      = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ERASE      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PLAY_START = 2'd2;
   localparam logic [CMD_W-1:0] CMD_PLAY_NEXT  = 2'd3;

   localparam logic [TICK_W-1:0] TICK_MS_RESET = 8'd20;
   localparam logic [DUR_W-1:0]  DUR_MAX       = 16'hFFFF;
   localparam logic [DUR_W-1:0]  DUR_SILENT    = 16'd1;

   // one ring entry
   typedef struct packed {
      logic [KEYS_W-1:0] mask;
      logic [DUR_W-1:0]  dur;
      logic [TONE_W-1:0] tone;
   } note_type;

   // request payload, last field in the lowest bits
   typedef struct packed {
      logic [1:0]       pad;
      logic             recording;
      logic [KEY_W-1:0] keys_high;
      logic [KEY_W-1:0] keys_mid;
      logic [KEY_W-1:0] keys_low;
   } req_type;

   // result payload, last field in the lowest bits
   typedef struct packed {
      logic [CNT_OUT_W-1:0] stored_count;
      logic                 entry_valid;
      logic [KEY_W-1:0]     lamps_high;
      logic [KEY_W-1:0]     lamps_mid;
      logic [KEY_W-1:0]     lamps_low;
      logic [DUR_W-1:0]     duration_ms;
      logic [TONE_W-1:0]    tone_hz;
   } rsp_type;

   // C-major scale over three octaves
   function automatic logic [TONE_W-1:0] scale_tone(input logic [4:0] idx);
      logic [TONE_W-1:0] hz;
      unique case (idx)
         5'd0:    hz = 11'd262;
         5'd1:    hz = 11'd294;
         5'd2:    hz = 11'd330;
         5'd3:    hz = 11'd349;
         5'd4:    hz = 11'd392;
         5'd5:    hz = 11'd440;
         5'd6:    hz = 11'd494;
         5'd7:    hz = 11'd523;
         5'd8:    hz = 11'd587;
         5'd9:    hz = 11'd659;
         5'd10:   hz = 11'd698;
         5'd11:   hz = 11'd784;
         5'd12:   hz = 11'd880;
         5'd13:   hz = 11'd988;
         5'd14:   hz = 11'd1046;
         5'd15:   hz = 11'd1174;
         5'd16:   hz = 11'd1318;
         5'd17:   hz = 11'd1397;
         5'd18:   hz = 11'd1568;
         5'd19:   hz = 11'd1760;
         5'd20:   hz = 11'd1976;
         default: hz = '0;
      endcase
      return hz;
   endfunction

   // lowest set bit of a group, 6 when the group is empty
   function automatic logic [2:0] lowest_key(input logic [KEY_W-1:0] grp);
      logic [2:0] idx;
      idx = 3'd6;
      for (int b = KEY_W - 1; b >= 0; b--) begin
         if (grp[b]) begin
            idx = 3'(b);
         end
      end
      return idx;
   endfunction

   // first non-empty group wins, bit 6 is C
   function automatic logic [TONE_W-1:0] key_tone(input logic [KEY_W-1:0] lo,
                                                  input logic [KEY_W-1:0] mid,
                                                  input logic [KEY_W-1:0] hi);
      logic [TONE_W-1:0] hz;
      priority if (lo != '0) begin
         hz = scale_tone(5'd6 - {2'b00, lowest_key(lo)});
      end else if (mid != '0) begin
         hz = scale_tone(5'd13 - {2'b00, lowest_key(mid)});
      end else if (hi != '0) begin
         hz = scale_tone(5'd20 - {2'b00, lowest_key(hi)});
      end else begin
         hz = '0;
      end
      return hz;
   endfunction

endpackage

@@ hdl/knr_ring.sv @@
module knr_ring #(
   parameter int DEPTH = 128,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  knr_pkg::note_type wdata,
   input  logic              re,
   input  logic [AW-1:0]     raddr,
   output knr_pkg::note_type rdata
);
   import knr_pkg::*;

   note_type ring_mem [DEPTH];
   note_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         ring_mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= ring_mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/key_note_recorder.sv @@
// Tick, erase and play-next past the end: result registered in the cycle after accept;
// next item may follow in the next cycle when the result is taken.
// Play-next with a stored note: the ring memory read is registered, then ST_FETCH loads the result.
// Play-start on a non-empty ring: result registered at accept, input held off in ST_FIX
// for the read-modify-write of the oldest entry.
// Synchronous reset clears pointers, held note and result valid, sets tick_ms to 20; ring kept.
`include "key_note_recorder_defines.svh"

module key_note_recorder #(
   parameter int RING_DEPTH = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [knr_pkg::TICK_W-1:0]     csr_wdata,      // tick_ms
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // keys_low, keys_mid, keys_high, recording, zero fill
   input  logic [knr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [knr_pkg::CMD_W-1:0]      req_tuser,      // command
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tone_hz, duration_ms, lamps_low, lamps_mid, lamps_high, entry_valid, stored_count
   output logic [knr_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import knr_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = (AW + 1 > CNT_OUT_W) ? AW + 1 : CNT_OUT_W;
   localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_FIX   = 2'd2;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] s);
      return (s == LAST) ? '0 : s + AW'(1);
   endfunction

   logic [TICK_W-1:0] tick_ms_ff, tick_ms_in;
   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     oldest_ff, oldest_in;
   logic [AW-1:0]     next_ff, next_in;
   logic [AW-1:0]     cursor_ff, cursor_in;
   logic [KEYS_W-1:0] held_keys_ff, held_keys_in;
   logic [TONE_W-1:0] held_tone_ff, held_tone_in;
   logic [DUR_W-1:0]  held_ticks_ff, held_ticks_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   req_type                 req;
   logic                    accept;
   logic [KEYS_W-1:0]       now_keys;
   logic [DUR_W+TICK_W-1:0] ms_full;
   logic [DUR_W-1:0]        ms_sat;
   logic [AW-1:0]           next_wrap, oldest_adv, cursor_adv;
   logic [CW-1:0]           count_full;
   logic                    rsp_load;
   rsp_type                 rsp_build;

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   note_type      mem_wdata, mem_rdata;

   knr_ring #(.DEPTH(RING_DEPTH)) u_ring (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign req        = req_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign now_keys   = {req.keys_high, req.keys_mid, req.keys_low};
   assign ms_full    = (DUR_W+TICK_W)'(held_ticks_ff) * (DUR_W+TICK_W)'(tick_ms_ff);
   assign ms_sat     = (ms_full > (DUR_W+TICK_W)'(DUR_MAX)) ? DUR_MAX : ms_full[DUR_W-1:0];
   assign next_wrap  = ring_next(next_ff);
   assign oldest_adv = ring_next(oldest_ff);
   assign cursor_adv = ring_next(cursor_ff);

   assign count_full = (next_in >= oldest_in)
                     ? CW'(next_in) - CW'(oldest_in)
                     : CW'(next_in) + CW'(RING_DEPTH) - CW'(oldest_in);

   assign tick_ms_in = csr_we ? csr_wdata : tick_ms_ff;

   always_comb begin
      state_in      = state_ff;
      oldest_in     = oldest_ff;
      next_in       = next_ff;
      cursor_in     = cursor_ff;
      held_keys_in  = held_keys_ff;
      held_tone_in  = held_tone_ff;
      held_ticks_in = held_ticks_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = next_ff;
      mem_wdata     = '{mask: held_keys_ff, dur: ms_sat, tone: held_tone_ff};
      mem_raddr     = cursor_ff;
      rsp_load      = 1'b0;
      rsp_build     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  CMD_TICK: begin
                     rsp_load = 1'b1;
                     if (now_keys == held_keys_ff) begin
                        if (held_ticks_ff != DUR_MAX) begin
                           held_ticks_in = held_ticks_ff + DUR_W'(1);
                        end
                     end else begin
                        if (req.recording) begin
                           // store the finished note, drop the oldest when full
                           mem_we  = 1'b1;
                           next_in = next_wrap;
                           if (next_wrap == oldest_ff) begin
                              oldest_in = oldest_adv;
                              if (cursor_ff == oldest_ff) begin
                                 cursor_in = cursor_adv;
                              end
                           end
                        end
                        held_ticks_in = '0;
                        held_keys_in  = now_keys;
                        held_tone_in  = key_tone(req.keys_low, req.keys_mid, req.keys_high);
                     end
                     rsp_build.tone_hz    = held_tone_in;
                     rsp_build.lamps_low  = held_keys_in[KEY_W-1:0];
                     rsp_build.lamps_mid  = held_keys_in[2*KEY_W-1:KEY_W];
                     rsp_build.lamps_high = held_keys_in[KEYS_W-1:2*KEY_W];
                  end
                  CMD_ERASE: begin
                     rsp_load  = 1'b1;
                     next_in   = oldest_ff;
                     cursor_in = oldest_ff;
                  end
                  CMD_PLAY_START: begin
                     rsp_load  = 1'b1;
                     cursor_in = oldest_ff;
                     if (oldest_ff != next_ff) begin
                        mem_re    = 1'b1;
                        mem_raddr = oldest_ff;
                        state_in  = ST_FIX;
                     end
                  end
                  CMD_PLAY_NEXT: begin
                     if (cursor_ff != next_ff) begin
                        mem_re    = 1'b1;
                        mem_raddr = cursor_ff;
                        cursor_in = cursor_adv;
                        state_in  = ST_FETCH;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            rsp_load              = 1'b1;
            rsp_build.tone_hz     = mem_rdata.tone;
            rsp_build.duration_ms = mem_rdata.dur;
            rsp_build.lamps_low   = mem_rdata.mask[KEY_W-1:0];
            rsp_build.lamps_mid   = mem_rdata.mask[2*KEY_W-1:KEY_W];
            rsp_build.lamps_high  = mem_rdata.mask[KEYS_W-1:2*KEY_W];
            rsp_build.entry_valid = 1'b1;
            state_in              = ST_IDLE;
         end
         ST_FIX: begin
            // silent first note plays for 1 ms
            if (mem_rdata.tone == '0) begin
               mem_we    = 1'b1;
               mem_waddr = oldest_ff;
               mem_wdata = '{mask: mem_rdata.mask, dur: DUR_SILENT, tone: mem_rdata.tone};
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_build.stored_count = count_full[CNT_OUT_W-1:0];
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = rsp_load ? rsp_build : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ms_ff    <= TICK_MS_RESET;
         state_ff      <= ST_IDLE;
         oldest_ff     <= '0;
         next_ff       <= '0;
         cursor_ff     <= '0;
         held_keys_ff  <= '0;
         held_tone_ff  <= '0;
         held_ticks_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tick_ms_ff    <= tick_ms_in;
         state_ff      <= state_in;
         oldest_ff     <= oldest_in;
         next_ff       <= next_in;
         cursor_ff     <= cursor_in;
         held_keys_ff  <= held_keys_in;
         held_tone_ff  <= held_tone_in;
         held_ticks_ff <= held_ticks_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `KNR_ASSERT(a_busy_no_ready, (state_ff != ST_IDLE) |-> !req_tready, "input ready while busy")
   `KNR_ASSERT(a_fetch_slot_free, (state_ff == ST_FETCH) |-> !rsp_valid_ff, "result slot busy on fetch")
   `KNR_ASSERT(a_fix_one_cycle, (state_ff == ST_FIX) |=> (state_ff == ST_IDLE), "fix-up longer than one cycle")
   `KNR_ASSERT_ALWAYS(a_mem_one_port, !(mem_we && mem_re), "ring read and write in one cycle")
   `KNR_ASSERT(a_ptr_range, (oldest_ff <= LAST) && (next_ff <= LAST) && (cursor_ff <= LAST), "ring pointer out of range")

endmodule

@@ sim/key_note_recorder_tb.sv @@
module key_note_recorder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import knr_pkg::*;

   localparam int RING = 128;

   // C-major scale, lowest C first
   localparam logic [TONE_W-1:0] NOTE_HZ [21] = '{
      11'd262,  11'd294,  11'd330,  11'd349,  11'd392,  11'd440,  11'd494,
      11'd523,  11'd587,  11'd659,  11'd698,  11'd784,  11'd880,  11'd988,
      11'd1046, 11'd1174, 11'd1318, 11'd1397, 11'd1568, 11'd1760, 11'd1976
   };

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      req_type          body;
   } key_item_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [TICK_W-1:0]     csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = CMD_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // recorder state as the checker sees it
   logic [TONE_W-1:0] ring_tone [RING];
   logic [DUR_W-1:0]  ring_len  [RING];
   logic [KEYS_W-1:0] ring_keys [RING];
   int unsigned       oldest      = 0;
   int unsigned       free_slot   = 0;
   int unsigned       cursor      = 0;
   logic [KEYS_W-1:0] live_keys   = '0;
   logic [TONE_W-1:0] live_tone   = '0;
   logic [DUR_W-1:0]  live_ticks  = '0;
   logic [TICK_W-1:0] ms_per_tick = TICK_MS_RESET;

   key_item_type      strokes[$];
   rsp_type           awaited_outputs[$];
   int unsigned       sent_count  = 0;
   int unsigned       taken_count = 0;
   int unsigned       error_count = 0;
   int unsigned       items_made  = 0;
   int unsigned       req_gap     = 0;
   int unsigned       rsp_stall   = 0;
   bit                bursts_on   = 1'b1;
   logic [KEYS_W-1:0] last_keys   = '0;

   key_note_recorder #(
      .RING_DEPTH(RING)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int unsigned ring_step(input int unsigned s);
      return (s + 1 == RING) ? 0 : s + 1;
   endfunction

   // first non-empty group wins, its lowest set bit is the highest note of that octave
   function automatic logic [TONE_W-1:0] chord_tone(input logic [KEYS_W-1:0] keys);
      for (int g = 0; g < 3; g++) begin
         if (keys[g*KEY_W +: KEY_W] != '0) begin
            for (int b = 0; b < KEY_W; b++) begin
               if (keys[g*KEY_W + b]) begin
                  return NOTE_HZ[g*KEY_W + KEY_W - 1 - b];
               end
            end
         end
      end
      return '0;
   endfunction

   function automatic rsp_type apply_command(input logic [CMD_W-1:0] cmd, input req_type rq);
      rsp_type           res;
      logic [KEYS_W-1:0] now;
      logic [31:0]       ms;
      res = '0;
      case (cmd)
         CMD_TICK: begin
            now = {rq.keys_high, rq.keys_mid, rq.keys_low};
            if (now == live_keys) begin
               if (live_ticks != DUR_MAX) begin
                  live_ticks++;
               end
            end else begin
               if (rq.recording) begin
                  ms = 32'(live_ticks) * 32'(ms_per_tick);
                  ring_tone[free_slot] = live_tone;
                  ring_len[free_slot]  = (ms > 32'(DUR_MAX)) ? DUR_MAX : ms[DUR_W-1:0];
                  ring_keys[free_slot] = live_keys;
                  free_slot = ring_step(free_slot);
                  // full ring: drop the oldest note, drag the cursor along
                  if (free_slot == oldest) begin
                     if (cursor == oldest) begin
                        cursor = ring_step(cursor);
                     end
                     oldest = ring_step(oldest);
                  end
               end
               live_ticks = '0;
               live_keys  = now;
               live_tone  = chord_tone(now);
            end
            res.tone_hz = live_tone;
            {res.lamps_high, res.lamps_mid, res.lamps_low} = live_keys;
         end
         CMD_ERASE: begin
            free_slot = oldest;
            cursor    = oldest;
         end
         CMD_PLAY_START: begin
            cursor = oldest;
            if (oldest != free_slot && ring_tone[oldest] == '0) begin
               ring_len[oldest] = DUR_SILENT;
            end
         end
         CMD_PLAY_NEXT: begin
            if (cursor != free_slot) begin
               res.tone_hz     = ring_tone[cursor];
               res.duration_ms = ring_len[cursor];
               {res.lamps_high, res.lamps_mid, res.lamps_low} = ring_keys[cursor];
               res.entry_valid = 1'b1;
               cursor = ring_step(cursor);
            end
         end
      endcase
      res.stored_count = CNT_OUT_W'((free_slot + RING - oldest) % RING);
      return res;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void push_tick(input logic [KEYS_W-1:0] keys, input logic rec);
      key_item_type it;
      it.cmd  = CMD_TICK;
      it.body = '0;
      {it.body.keys_high, it.body.keys_mid, it.body.keys_low} = keys;
      it.body.recording = rec;
      strokes.push_back(it);
      last_keys = keys;
      items_made++;
   endfunction

   // keys and recording bit are don't-care on these commands: fill with noise
   function automatic void push_cmd(input logic [CMD_W-1:0] cmd);
      key_item_type it;
      it.cmd  = cmd;
      it.body = '0;
      {it.body.recording, it.body.keys_high, it.body.keys_mid, it.body.keys_low} =
         22'($urandom);
      strokes.push_back(it);
      items_made++;
   endfunction

   function automatic logic [KEYS_W-1:0] pick_chord();
      logic [KEYS_W-1:0] k;
      case ($urandom_range(0, 4))
         0:       k = '0;
         1, 2:    k = KEYS_W'(1) << $urandom_range(0, KEYS_W - 1);
         3:       k = KEYS_W'($urandom);
         default: begin
            k = KEYS_W'($urandom);
            k[$urandom_range(0, 2)*KEY_W +: KEY_W] = '0;
         end
      endcase
      return k;
   endfunction

   function automatic logic [KEYS_W-1:0] fresh_chord();
      logic [KEYS_W-1:0] k;
      k = pick_chord();
      if (k == last_keys) begin
         k = k ^ (KEYS_W'(1) << $urandom_range(0, KEYS_W - 1));
      end
      return k;
   endfunction

   function automatic void push_hold(input int unsigned n);
      repeat (n) begin
         push_tick(last_keys, 1'($urandom));
      end
   endfunction

   function automatic void push_playback(input int unsigned n);
      push_cmd(CMD_PLAY_START);
      repeat (n) begin
         push_cmd(CMD_PLAY_NEXT);
      end
   endfunction

   function automatic void add_random_stretch();
      int unsigned       pick;
      logic [CMD_W-1:0]  cmd;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         // a melody: mostly recorded, notes held for a few ticks
         repeat ($urandom_range(1, 12)) begin
            push_tick(fresh_chord(), $urandom_range(0, 9) != 0);
            push_hold(($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
         end
      end else if (pick < 75) begin
         push_playback(($urandom_range(0, 5) == 0) ? $urandom_range(100, RING + 6)
                                                   : $urandom_range(1, 20));
      end else if (pick < 90) begin
         repeat ($urandom_range(1, 6)) begin
            cmd = CMD_W'($urandom);
            if (cmd == CMD_TICK) begin
               push_tick(pick_chord(), 1'($urandom));
            end else begin
               push_cmd(cmd);
            end
         end
      end else if (pick < 96) begin
         repeat ($urandom_range(1, 3)) begin
            push_cmd(CMD_PLAY_NEXT);
         end
      end else begin
         push_cmd(CMD_ERASE);
      end
   endfunction

   function automatic void run_random(input int unsigned n);
      int unsigned start;
      start = items_made;
      while (items_made - start < n) begin
         add_random_stretch();
      end
   endfunction

   task automatic wait_drained();
      while (strokes.size() != 0 || taken_count != sent_count || awaited_outputs.size() != 0)
      begin
         @(negedge clock);
      end
      // play start may still hold the ring for its read-modify-write
      repeat (4) @(negedge clock);
   endtask

   task automatic write_tick_ms(input logic [TICK_W-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      ms_per_tick = v;
   endtask

   always @(negedge clock) begin : stroke_driver
      key_item_type it;
      if (!reset && taken_count == sent_count) begin
         if (bursts_on && req_gap != 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (strokes.size() != 0) begin
            it = strokes.pop_front();
            req_tuser  <= it.cmd;
            req_tdata  <= it.body;
            req_tvalid <= 1'b1;
            sent_count++;
            if (bursts_on && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : result_sink
      if (!reset) begin
         if (bursts_on && rsp_stall != 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (bursts_on && $urandom_range(0, 5) == 0) begin
               rsp_stall = $urandom_range(1, 8);
            end
         end
      end
   end

   always @(posedge clock) begin : output_monitor
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (awaited_outputs.size() == 0) begin
               $error("unexpected result item: %h", rsp_tdata);
               error_count++;
            end else begin
               want = awaited_outputs.pop_front();
               check_field("tone_hz", want.tone_hz, got.tone_hz);
               check_field("duration_ms", want.duration_ms, got.duration_ms);
               check_field("lamps_low", want.lamps_low, got.lamps_low);
               check_field("lamps_mid", want.lamps_mid, got.lamps_mid);
               check_field("lamps_high", want.lamps_high, got.lamps_high);
               check_field("entry_valid", want.entry_valid, got.entry_valid);
               check_field("stored_count", want.stored_count, got.stored_count);
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_outputs.push_back(apply_command(req_tuser, req_tdata));
            taken_count++;
         end
      end
   end

   initial begin : stimulus
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // empty ring, then a short recorded tune at the reset tick length
      push_cmd(CMD_PLAY_NEXT);
      push_cmd(CMD_PLAY_START);
      push_cmd(CMD_ERASE);
      push_tick({7'h00, 7'h00, 7'h00}, 1'b1);
      push_tick({7'h00, 7'h00, 7'h40}, 1'b1);
      push_tick({7'h00, 7'h00, 7'h40}, 1'b1);
      push_tick({7'h00, 7'h00, 7'h01}, 1'b1);
      push_tick({7'h00, 7'h7F, 7'h00}, 1'b1);
      push_tick({7'h40, 7'h00, 7'h00}, 1'b1);
      push_tick({7'h01, 7'h00, 7'h00}, 1'b0);
      push_tick({7'h7F, 7'h7F, 7'h7F}, 1'b1);
      push_tick({7'h00, 7'h00, 7'h00}, 1'b1);
      // first stored note is silent: play start shortens it
      push_playback(7);
      push_cmd(CMD_ERASE);
      push_cmd(CMD_PLAY_NEXT);
      push_cmd(CMD_PLAY_START);
      push_tick({7'h2A, 7'h55, 7'h20}, 1'b1);
      push_cmd(CMD_PLAY_NEXT);
      wait_drained();

      // longest tick: exact fit and overflow of the duration
      write_tick_ms(8'd255);
      push_tick(fresh_chord(), 1'b1);
      push_hold(257);
      push_tick(fresh_chord(), 1'b1);
      push_hold(258);
      push_tick(fresh_chord(), 1'b1);
      push_playback(RING + 2);
      run_random(100);
      wait_drained();

      // shortest tick: a held note at one millisecond per tick
      write_tick_ms(8'd1);
      push_tick(fresh_chord(), 1'b1);
      push_hold(40);
      push_tick(fresh_chord(), 1'b1);
      push_playback(RING + 2);
      run_random(100);
      wait_drained();

      // overrun the ring with the cursor parked on the oldest note
      write_tick_ms(TICK_W'($urandom_range(2, 254)));
      push_cmd(CMD_PLAY_START);
      repeat (150) begin
         push_tick(fresh_chord(), 1'b1);
         if ($urandom_range(0, 9) == 0) begin
            push_cmd(CMD_PLAY_NEXT);
         end
      end
      push_playback(RING + 2);
      run_random(100);
      wait_drained();

      write_tick_ms(TICK_W'($urandom_range(1, 255)));
      bursts_on = 1'b0;
      run_random(150);
      wait_drained();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : watchdog
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/knr_pkg.sv
hdl/knr_ring.sv
hdl/key_note_recorder.sv
sim/key_note_recorder_tb.sv
